// File: rtl/core/vpa_pkg.sv
// Package for the variable partition allocator: types, codes and defaults.
package vpa_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int ADDR_BITS_DEF = 16;
    localparam logic [15:0] TOTAL_SIZE_RESET = 16'd640;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_BAD_SIZE   = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_TABLE_FULL = 3'd4
    } status_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_FIT_MODE   = 1'b0;
    localparam logic REG_TOTAL_SIZE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] request_size;
        logic [15:0] free_base;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] base_address;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_MERGE_NEXT,
        S_DONE
    } state_t;

endpackage

// File: rtl/core/variable_partition_allocator_top.sv
// Top level of the variable partition allocator.
//
// Usage: raise start with a command item (allocate or free); it is taken at a
// clock edge where start is high and busy is low. Busy stays high while the
// segment table is scanned and reshaped. The result item (status, base) is
// shown for one cycle with done high; the receiver cannot stall it.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 is fit mode,
// 1 is total size (which reinitialises the table). Write only while idle.
// Operation: one scan over the live segments (one entry a cycle; first fit and a
// free may stop early), then on a split one shift pass up, on a free up to two
// shift passes down; each pass walks the table one entry per cycle. One item at
// a time.
// Reset: fit mode first fit, total size 640, one free segment at base zero.
module variable_partition_allocator_top
    import vpa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic    cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ADDR_BITS = ADDR_BITS_DEF;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

    // Segment table in registers
    logic [ADDR_BITS-1:0] base_reg [MAX_SEGMENTS];
    logic [ADDR_BITS-1:0] len_reg  [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] busy_bits_reg;
    logic [CW-1:0] count_reg;
    logic fit_mode_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] pick_reg, pick_next;
    logic found_reg, found_next;
    cmd_t cmd_reg;
    logic [2:0] status_reg, status_next;
    logic [15:0] out_base_reg, out_base_next;
    logic [ADDR_BITS-1:0] size_w, fbase_w;

    // Shared unit operands
    logic [IW-1:0] cur;
    logic [ADDR_BITS-1:0] cur_len, cur_base, pick_len;
    logic cur_busy;

    assign size_w  = ADDR_BITS'(cmd_reg.request_size);
    assign fbase_w = ADDR_BITS'(cmd_reg.free_base);
    assign cur      = idx_reg[IW-1:0];
    assign cur_len  = len_reg[cur];
    assign cur_base = base_reg[cur];
    assign cur_busy = busy_bits_reg[cur];
    assign pick_len = len_reg[pick_reg];

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign done      = (state_reg == S_DONE);
    assign result.status       = status_reg;
    assign result.base_address = out_base_reg;

    // Table update controls
    typedef enum logic [2:0] {
        T_NONE, T_MARK, T_SPLIT_MOVE, T_SPLIT_FIX, T_FREE_MARK, T_MOVE_DOWN, T_ADD
    } tbl_op_t;
    tbl_op_t op;
    logic [IW-1:0] add_dst;
    logic cnt_inc, cnt_dec;

    // Next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pick_next     = pick_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        out_base_next = out_base_reg;
        op      = T_NONE;
        add_dst = pick_reg;
        cnt_inc = 1'b0;
        cnt_dec = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                pick_next  = '0;
                out_base_next = '0;
                if (start)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cmd_reg.command == CMD_ALLOC && size_w == '0) begin
                    status_next = ST_BAD_SIZE;
                    state_next  = S_DONE;
                end else if (idx_reg >= count_reg) begin
                    state_next = S_DECIDE;
                end else if (cmd_reg.command == CMD_ALLOC) begin
                    idx_next = idx_reg + 1'b1;
                    if (!cur_busy && cur_len >= size_w) begin
                        if (!found_reg || cur_len < pick_len)
                            pick_next = cur;
                        found_next = 1'b1;
                        if (!fit_mode_reg) begin
                            pick_next  = cur;
                            state_next = S_DECIDE;
                        end
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                    if (cur_busy && cur_base == fbase_w) begin
                        pick_next  = cur;
                        found_next = 1'b1;
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (!found_reg) begin
                    status_next = (cmd_reg.command == CMD_ALLOC) ? ST_NO_SPACE
                                                                : ST_NOT_FOUND;
                end else if (cmd_reg.command == CMD_ALLOC) begin
                    if (pick_len == size_w) begin
                        op = T_MARK;
                        status_next   = ST_OK;
                        out_base_next = 16'(base_reg[pick_reg]);
                    end else if (count_reg >= CNT_MAX) begin
                        status_next = ST_TABLE_FULL;
                    end else begin
                        status_next   = ST_OK;
                        out_base_next = 16'(base_reg[pick_reg]);
                        idx_next   = count_reg;
                        state_next = S_SHIFT_UP;
                    end
                end else begin
                    status_next = ST_OK;
                    op = T_FREE_MARK;
                    if (pick_reg != '0 && !busy_bits_reg[pick_reg - 1'b1]) begin
                        // absorb into left neighbour
                        op = T_ADD;
                        add_dst = pick_reg - 1'b1;
                        idx_next = CW'(pick_reg);
                        pick_next = pick_reg - 1'b1;
                        state_next = S_SHIFT_DOWN;
                    end else begin
                        state_next = S_MERGE_NEXT;
                    end
                end
            end
            S_SHIFT_UP:
            begin
                // move entry idx-1 to idx, stop when at pick+1
                if (idx_reg > CW'(pick_reg) + 1'b1) begin
                    op = T_SPLIT_MOVE;
                    idx_next = idx_reg - 1'b1;
                end else begin
                    op = T_SPLIT_FIX;
                    cnt_inc = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHIFT_DOWN:
            begin
                // move entry idx+1 to idx until the end
                if (idx_reg + 1'b1 < count_reg) begin
                    op = T_MOVE_DOWN;
                    idx_next = idx_reg + 1'b1;
                end else begin
                    cnt_dec = 1'b1;
                    state_next = found_reg ? S_MERGE_NEXT : S_DONE;
                end
            end
            S_MERGE_NEXT:
            begin
                found_next = 1'b0;
                state_next = S_DONE;
                if (CW'(pick_reg) + 1'b1 < count_reg && !busy_bits_reg[pick_reg + 1'b1]) begin
                    op = T_ADD;
                    add_dst = pick_reg;
                    idx_next = CW'(pick_reg) + 1'b1;
                    state_next = S_SHIFT_DOWN;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            pick_reg     <= '0;
            found_reg    <= 1'b0;
            status_reg   <= '0;
            out_base_reg <= '0;
            fit_mode_reg <= 1'b0;
            count_reg    <= CW'(1);
            busy_bits_reg <= '0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            pick_reg     <= pick_next;
            found_reg    <= found_next;
            status_reg   <= status_next;
            out_base_reg <= out_base_next;
            if (cnt_inc)
                count_reg <= count_reg + 1'b1;
            if (cnt_dec)
                count_reg <= count_reg - 1'b1;
            unique case (op)
                T_MARK:       busy_bits_reg[pick_reg] <= 1'b1;
                T_SPLIT_MOVE: busy_bits_reg[cur] <= busy_bits_reg[cur - 1'b1];
                T_SPLIT_FIX:
                begin
                    busy_bits_reg[pick_reg]        <= 1'b1;
                    busy_bits_reg[pick_reg + 1'b1] <= 1'b0;
                end
                T_FREE_MARK:  busy_bits_reg[pick_reg] <= 1'b0;
                T_MOVE_DOWN:  busy_bits_reg[cur] <= busy_bits_reg[cur + 1'b1];
                T_ADD:        busy_bits_reg[pick_reg] <= 1'b0;
                default:      ;
            endcase
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FIT_MODE)
                    fit_mode_reg <= cfg_data[0];
                else begin
                    count_reg     <= CW'(1);
                    busy_bits_reg <= '0;
                end
            end
        end
    end

    // Segment payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            base_reg[0] <= '0;
            len_reg[0]  <= ADDR_BITS'(TOTAL_SIZE_RESET);
        end else begin
            unique case (op)
                T_SPLIT_MOVE:
                begin
                    base_reg[cur] <= base_reg[cur - 1'b1];
                    len_reg[cur]  <= len_reg[cur - 1'b1];
                end
                T_SPLIT_FIX:
                begin
                    len_reg[pick_reg]         <= size_w;
                    base_reg[pick_reg + 1'b1] <= base_reg[pick_reg] + size_w;
                    len_reg[pick_reg + 1'b1]  <= len_reg[pick_reg] - size_w;
                end
                T_MOVE_DOWN:
                begin
                    base_reg[cur] <= base_reg[cur + 1'b1];
                    len_reg[cur]  <= len_reg[cur + 1'b1];
                end
                T_ADD:
                    len_reg[add_dst] <= len_reg[add_dst] + len_reg[add_dst + 1'b1];
                default: ;
            endcase
            if (cfg_valid && cfg_ready && cfg_index == REG_TOTAL_SIZE) begin
                base_reg[0] <= '0;
                len_reg[0]  <= ADDR_BITS'(cfg_data);
            end
        end
    end

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            cmd_reg <= cmd;
    end

endmodule

// File: tb/tb.sv
// Testbench for the variable partition allocator: directed table, random commands, live predictor.
`timescale 1ns / 1ps

module tb;
    import vpa_pkg::*;

    localparam int SEGS = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    cmd_t        cmd = '0;
    logic        done;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    variable_partition_allocator_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Predictor state: segment table and configuration
    logic        pr_mode;
    logic [15:0] pr_total;
    logic [15:0] seg_base [SEGS];
    logic [15:0] seg_len  [SEGS];
    logic        seg_busy [SEGS];
    int          seg_cnt;

    result_t     pending_results [$];
    int          errors = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_fail_status [5];
    bit          idle_on = 1'b1;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void table_clear();
        for (int i = 0; i < SEGS; i++)
        begin
            seg_base[i] = '0; seg_len[i] = '0; seg_busy[i] = 1'b0;
        end
        seg_len[0] = pr_total;
        seg_cnt = 1;
    endfunction

    function automatic void table_drop(input int pos);
        for (int i = pos; i + 1 < seg_cnt; i++)
        begin
            seg_base[i] = seg_base[i+1]; seg_len[i] = seg_len[i+1];
            seg_busy[i] = seg_busy[i+1];
        end
        seg_cnt--;
    endfunction

    function automatic result_t predict_command(input cmd_t c);
        result_t r;
        int pick;
        bit found;
        r = '0;
        r.status = ST_OK;
        pick = 0;
        found = 1'b0;
        if (c.command == CMD_ALLOC)
        begin
            if (c.request_size == 0)
                r.status = ST_BAD_SIZE;
            else
            begin
                for (int i = 0; i < seg_cnt; i++)
                begin
                    if (!seg_busy[i] && seg_len[i] >= c.request_size)
                    begin
                        if (!found)
                        begin
                            pick = i; found = 1'b1;
                            if (pr_mode == 1'b0) break;
                        end
                        else if (seg_len[i] < seg_len[pick])
                            pick = i;
                    end
                end
                if (!found)
                    r.status = ST_NO_SPACE;
                else if (seg_len[pick] == c.request_size)
                begin
                    seg_busy[pick] = 1'b1;
                    r.base_address = seg_base[pick];
                end
                else if (seg_cnt >= SEGS)
                    r.status = ST_TABLE_FULL;
                else
                begin
                    for (int i = seg_cnt; i > pick; i--)
                    begin
                        seg_base[i] = seg_base[i-1]; seg_len[i] = seg_len[i-1];
                        seg_busy[i] = seg_busy[i-1];
                    end
                    seg_cnt++;
                    seg_len[pick] = c.request_size;
                    seg_busy[pick] = 1'b1;
                    seg_base[pick+1] = seg_base[pick] + c.request_size;
                    seg_len[pick+1] = seg_len[pick+1] - c.request_size;
                    seg_busy[pick+1] = 1'b0;
                    r.base_address = seg_base[pick];
                end
            end
        end
        else
        begin
            for (int i = 0; i < seg_cnt; i++)
            begin
                if (seg_busy[i] && seg_base[i] == c.free_base)
                begin
                    pick = i; found = 1'b1; break;
                end
            end
            if (!found)
                r.status = ST_NOT_FOUND;
            else
            begin
                seg_busy[pick] = 1'b0;
                if (pick > 0 && !seg_busy[pick-1])
                begin
                    seg_len[pick-1] = seg_len[pick-1] + seg_len[pick];
                    table_drop(pick);
                    pick--;
                end
                if (pick + 1 < seg_cnt && !seg_busy[pick+1])
                begin
                    seg_len[pick] = seg_len[pick] + seg_len[pick+1];
                    table_drop(pick + 1);
                end
            end
        end
        return r;
    endfunction

    // Check each result item against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                result_t e;
                e = pending_results.pop_front();
                if (result.status !== e.status)
                    report_mismatch($sformatf("status %0d expected %0d",
                        result.status, e.status));
                if (result.base_address !== e.base_address)
                    report_mismatch($sformatf("base %0d expected %0d",
                        result.base_address, e.base_address));
                n_results++;
                if (e.status <= 4) n_fail_status[e.status]++;
            end
        end
    end

    task automatic idle_gap();
        while (idle_on && $urandom_range(99) < 17)
            @(posedge clk);
    endtask

    // Issue one command item and queue its prediction
    task automatic issue(input cmd_t c);
        idle_gap();
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_command(c));
        n_items++;
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Issue with a typed-in expectation checked against the predictor too
    task automatic issue_known(input cmd_t c, input result_t want);
        result_t got;
        got = predict_command(c);
        if (got !== want)
            report_mismatch("directed row disagrees with predictor");
        idle_gap();
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(want);
        n_items++;
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3 * SEGS + 10) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_FIT_MODE)
            pr_mode = val[0];
        else
        begin
            pr_total = val;
            table_clear();
        end
        @(posedge clk);
    endtask

    function automatic cmd_t mk(input logic op, input logic [15:0] sz, input logic [15:0] fb);
        cmd_t c;
        c.command = op; c.request_size = sz; c.free_base = fb;
        return c;
    endfunction

    function automatic result_t rs(input status_t s, input logic [15:0] b);
        result_t r;
        r.status = s; r.base_address = b;
        return r;
    endfunction

    // Directed rows: op, size, base, expected status, expected base, known flag
    typedef struct {
        logic        op;
        logic [15:0] sz;
        logic [15:0] fb;
        status_t     st;
        logic [15:0] ba;
        bit          known;
    } row_t;

    // Random allocate or free; frees mostly pick a live busy base
    function automatic cmd_t random_command(input int cap);
        cmd_t c;
        int busy_idx [$];
        c = mk(CMD_ALLOC, 16'($urandom_range(1, cap)), 16'($urandom));
        if ($urandom_range(99) < 4) c.request_size = 16'($urandom);
        if ($urandom_range(99) < 3) c.request_size = 0;
        if ($urandom_range(99) < 45)
        begin
            c.command = CMD_FREE;
            for (int i = 0; i < seg_cnt; i++)
                if (seg_busy[i]) busy_idx.push_back(i);
            if (busy_idx.size() != 0 && $urandom_range(99) < 85)
                c.free_base = seg_base[busy_idx[$urandom_range(busy_idx.size() - 1)]];
        end
        return c;
    endfunction

    initial
    begin
        row_t rows [$];
        pr_mode = 1'b0;
        pr_total = TOTAL_SIZE_RESET;
        table_clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part after reset, first fit, region 640
        rows = '{
            '{CMD_ALLOC, 16'd0,     16'd0,   ST_BAD_SIZE,  16'd0,   1},
            '{CMD_ALLOC, 16'd641,   16'd0,   ST_NO_SPACE,  16'd0,   1},
            '{CMD_ALLOC, 16'hFFFF,  16'd0,   ST_NO_SPACE,  16'd0,   1},
            '{CMD_ALLOC, 16'd100,   16'd0,   ST_OK,        16'd0,   1},
            '{CMD_ALLOC, 16'd50,    16'd0,   ST_OK,        16'd100, 1},
            '{CMD_ALLOC, 16'd200,   16'd0,   ST_OK,        16'd150, 1},
            '{CMD_FREE,  16'd0,     16'd350, ST_NOT_FOUND, 16'd0,   1},
            '{CMD_FREE,  16'd0,     16'hFFFF,ST_NOT_FOUND, 16'd0,   1},
            '{CMD_FREE,  16'hFFFF,  16'd100, ST_OK,        16'd0,   1},
            '{CMD_FREE,  16'd0,     16'd100, ST_NOT_FOUND, 16'd0,   1},
            '{CMD_ALLOC, 16'd50,    16'd0,   ST_OK,        16'd100, 1},
            '{CMD_FREE,  16'd0,     16'd0,   ST_OK,        16'd0,   0},
            '{CMD_FREE,  16'd0,     16'd150, ST_OK,        16'd0,   0},
            '{CMD_FREE,  16'd0,     16'd100, ST_OK,        16'd0,   0},
            '{CMD_ALLOC, 16'd640,   16'd0,   ST_OK,        16'd0,   1},
            '{CMD_ALLOC, 16'd1,     16'd0,   ST_NO_SPACE,  16'd0,   1},
            '{CMD_FREE,  16'd0,     16'd0,   ST_OK,        16'd0,   1}
        };
        foreach (rows[i])
        begin
            if (rows[i].known)
                issue_known(mk(rows[i].op, rows[i].sz, rows[i].fb), rs(rows[i].st, rows[i].ba));
            else
                issue(mk(rows[i].op, rows[i].sz, rows[i].fb));
        end

        // Fill the table with single units to hit the full-table split
        for (int i = 0; i < SEGS; i++)
            issue(mk(CMD_ALLOC, 16'd1, 16'd0));
        issue_known(mk(CMD_ALLOC, 16'd640, 16'd0), rs(ST_NO_SPACE, 16'd0));

        // Best fit with holes of differing sizes, then region extremes
        write_reg(REG_FIT_MODE, 16'hFFFF);
        write_reg(REG_TOTAL_SIZE, 16'd300);
        issue(mk(CMD_ALLOC, 16'd40, 16'd0));
        issue(mk(CMD_ALLOC, 16'd10, 16'd0));
        issue(mk(CMD_ALLOC, 16'd20, 16'd0));
        issue(mk(CMD_ALLOC, 16'd10, 16'd0));
        issue(mk(CMD_FREE, 16'd0, 16'd0));
        issue(mk(CMD_FREE, 16'd0, 16'd50));
        issue(mk(CMD_ALLOC, 16'd15, 16'd0));
        write_reg(REG_TOTAL_SIZE, 16'd0);
        issue_known(mk(CMD_ALLOC, 16'd1, 16'd0), rs(ST_NO_SPACE, 16'd0));
        write_reg(REG_TOTAL_SIZE, 16'hFFFF);
        issue_known(mk(CMD_ALLOC, 16'hFFFF, 16'd0), rs(ST_OK, 16'd0));
        issue_known(mk(CMD_FREE, 16'd0, 16'd0), rs(ST_OK, 16'd0));

        // Random phases through several settings; phase 2 runs without idling
        for (int ph = 0; ph < 6; ph++)
        begin
            int cap;
            logic [15:0] tot;
            case (ph)
                0: tot = 16'd640;
                1: tot = 16'd1;
                2: tot = 16'hFFFF;
                default: tot = 16'($urandom_range(20, 2000));
            endcase
            write_reg(REG_FIT_MODE, 16'($urandom));
            write_reg(REG_TOTAL_SIZE, tot);
            idle_on = (ph != 2);
            cap = (tot < 16) ? 1 : tot / 6;
            repeat (85)
                issue(random_command(cap));
        end
        idle_on = 1'b1;

        drain();
        $display("Covered %0d commands over both fit modes and region sizes 0 to 65535;",
            n_items);
        $display("statuses ok/nospace/badsize/notfound/full: %0d %0d %0d %0d %0d",
            n_fail_status[0], n_fail_status[1], n_fail_status[2],
            n_fail_status[3], n_fail_status[4]);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard limit on run time
    initial
    begin
        #2ms;
        $display("Timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/vpa_pkg.sv
rtl/core/variable_partition_allocator_top.sv
tb/tb.sv
